>>> rtl/gdd_pkg.sv
package gdd_pkg;

	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned COUNT_W  = 22;
	localparam int unsigned QUO_W    = 7;   // year / 100 stays below 100
	localparam int unsigned PROD_W   = 27;  // 14-bit year times 13-bit reciprocal

	localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for all x below 2^14
	localparam logic [12:0]  RECIP_100   = 13'd5243;
	localparam int unsigned  RECIP_SHIFT = 19;
	localparam logic [8:0]   DAYS_YEAR   = 9'd365;
	localparam logic [6:0]   HUNDRED     = 7'd100;

	typedef struct packed {
		logic load;     // capture the request fields
		logic sel_end;  // work on the end date
		logic mul_p;    // years before: multiply step
		logic mul_y;    // year / 100 step
		logic leap;     // leap flag and year part of the serial
		logic sum;      // month and day part, store serial
		logic finish;   // compare serials, load the result register
	} gdd_cmd_t;

	function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/gdd_dp.sv
module gdd_dp
	import gdd_pkg::*;
(
	input  logic                clk,
	input  gdd_cmd_t            cmd,
	input  logic [YEAR_W-1:0]   start_year,
	input  logic [MONTH_W-1:0]  start_month,
	input  logic [DAY_W-1:0]    start_day,
	input  logic [YEAR_W-1:0]   end_year,
	input  logic [MONTH_W-1:0]  end_month,
	input  logic [DAY_W-1:0]    end_day,
	output logic [COUNT_W-1:0]  day_count,
	output logic                order_error
);

	logic [YEAR_W-1:0]  sy_q, ey_q;
	logic [MONTH_W-1:0] sm_q, em_q;
	logic [DAY_W-1:0]   sd_q, ed_q;

	logic [YEAR_W-1:0]  y_raw, y_c, p;
	logic [MONTH_W-1:0] m_raw, m_c;
	logic [DAY_W-1:0]   d;

	logic [QUO_W-1:0]   qp_q, qy_q;
	logic [COUNT_W-1:0] base_q, part_q, a_q, b_q;
	logic               leap_q;

	logic [PROD_W-1:0]  prod;
	logic [YEAR_W-1:0]  rem_y;
	logic [COUNT_W-1:0] serial;

	always_comb begin
		y_raw = cmd.sel_end ? ey_q : sy_q;
		m_raw = cmd.sel_end ? em_q : sm_q;
		d     = cmd.sel_end ? ed_q : sd_q;
		priority if (y_raw < YEAR_MIN) y_c = YEAR_MIN;
		else if (y_raw > YEAR_MAX)     y_c = YEAR_MAX;
		else                           y_c = y_raw;
		priority if (m_raw < MONTH_MIN) m_c = MONTH_MIN;
		else if (m_raw > MONTH_MAX)     m_c = MONTH_MAX;
		else                            m_c = m_raw;
		p = y_c - YEAR_MIN;
	end

	// one reciprocal multiplier, shared by the p / 100 and y / 100 steps
	assign prod = PROD_W'(cmd.mul_y ? y_c : p) * PROD_W'(RECIP_100);

	// y mod 100
	assign rem_y = y_c - YEAR_W'(qy_q) * YEAR_W'(HUNDRED);

	assign serial = part_q + COUNT_W'(days_before_month(m_c))
		+ COUNT_W'((m_c > MONTH_FEB) && leap_q) + COUNT_W'(d);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sy_q <= start_year;
			sm_q <= start_month;
			sd_q <= start_day;
			ey_q <= end_year;
			em_q <= end_month;
			ed_q <= end_day;
		end
		if (cmd.mul_p) begin
			qp_q   <= prod[RECIP_SHIFT +: QUO_W];
			base_q <= COUNT_W'(p) * COUNT_W'(DAYS_YEAR);
		end
		if (cmd.mul_y) begin
			qy_q <= prod[RECIP_SHIFT +: QUO_W];
		end
		if (cmd.leap) begin
			// divisible by 4, and not by 100 unless also by 400
			leap_q <= (y_c[1:0] == 2'b00) && ((rem_y != '0) || (qy_q[1:0] == 2'b00));
			part_q <= base_q + COUNT_W'(p >> 2) - COUNT_W'(qp_q) + COUNT_W'(qp_q >> 2);
		end
		if (cmd.sum) begin
			if (cmd.sel_end) begin
				b_q <= serial;
			end else begin
				a_q <= serial;
			end
		end
		if (cmd.finish) begin
			if (b_q < a_q) begin
				day_count   <= '0;
				order_error <= 1'b1;
			end else begin
				day_count   <= b_q - a_q;
				order_error <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/gdd_ctrl.sv
module gdd_ctrl
	import gdd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output gdd_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_Y,
		ST_LEAP,
		ST_SUM,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   sel_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !(out_valid_q && out_stall);

	always_comb begin
		cmd         = '0;
		cmd.sel_end = sel_q;
		cmd.load    = (state_q == ST_IDLE) && in_valid;
		cmd.mul_p   = (state_q == ST_MUL_P);
		cmd.mul_y   = (state_q == ST_MUL_Y);
		cmd.leap    = (state_q == ST_LEAP);
		cmd.sum     = (state_q == ST_SUM);
		cmd.finish  = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace one that transfers at this edge
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					sel_q <= 1'b0;
					if (in_valid) begin
						state_q <= ST_MUL_P;
					end
				end
				ST_MUL_P: state_q <= ST_MUL_Y;
				ST_MUL_Y: state_q <= ST_LEAP;
				ST_LEAP:  state_q <= ST_SUM;
				ST_SUM: begin
					if (sel_q) begin
						state_q <= ST_FINISH;
					end else begin
						sel_q   <= 1'b1;
						state_q <= ST_MUL_P;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !sel_q))
		else $error("no busy after input transfer");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while held");

	a_end_before_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> sel_q)
		else $error("finish reached before end date done");

endmodule

>>> rtl/gregorian_day_difference_top.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_stall  | start_year, start_month, start_day, end_year, end_month, end_day
// out     | out_valid / out_stall| day_count, order_error
//
// The result is loaded after four sequencer steps per date (shared /100 multiplier,
// leap, sum) plus a compare; the next request can be taken in the cycle after the
// result is loaded, and not before.
// in_stall is high from the input transfer until the result is loaded.
// A held result does not block the next request; only its final compare waits.
// arst_n clears the sequencer and out_valid; data registers are not reset.
module gregorian_day_difference_top
	import gdd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [YEAR_W-1:0]   start_year,
	input  logic [MONTH_W-1:0]  start_month,
	input  logic [DAY_W-1:0]    start_day,
	input  logic [YEAR_W-1:0]   end_year,
	input  logic [MONTH_W-1:0]  end_month,
	input  logic [DAY_W-1:0]    end_day,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [COUNT_W-1:0]  day_count,
	output logic                order_error
);

	gdd_cmd_t cmd;

	gdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	gdd_dp u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.start_year  (start_year),
		.start_month (start_month),
		.start_day   (start_day),
		.end_year    (end_year),
		.end_month   (end_month),
		.end_day     (end_day),
		.day_count   (day_count),
		.order_error (order_error)
	);

endmodule

>>> tb/sv/tb_gregorian_day_difference_top.sv
`timescale 1ns / 100ps

module tb_gregorian_day_difference_top
	import gdd_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned RANDOM_PAIRS = 800;
	localparam int unsigned DATE_W       = YEAR_W + MONTH_W + DAY_W;

	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic               order_error;
	} date_gap_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [YEAR_W-1:0]  start_year;
	logic [MONTH_W-1:0] start_month;
	logic [DAY_W-1:0]   start_day;
	logic [YEAR_W-1:0]  end_year;
	logic [MONTH_W-1:0] end_month;
	logic [DAY_W-1:0]   end_day;
	logic               out_valid;
	logic               out_stall;
	logic [COUNT_W-1:0] day_count;
	logic               order_error;

	date_gap_t   pending_gaps[$];
	date_gap_t   want;
	int unsigned send_idle_max = 10;
	int unsigned sink_idle_max = 10;
	int unsigned sink_hold     = 0;
	int unsigned pairs_sent    = 0;
	int unsigned results_seen  = 0;
	int unsigned errors_seen   = 0;
	int unsigned mismatches    = 0;
	int unsigned cycle_count   = 0;

	gregorian_day_difference_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_year  (start_year),
		.start_month (start_month),
		.start_day   (start_day),
		.end_year    (end_year),
		.end_month   (end_month),
		.end_day     (end_day),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.day_count   (day_count),
		.order_error (order_error)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_gaps.size());
			$display("gregorian_day_difference_top: mismatch");
			$finish;
		end
	end

	// Serial day number counted from the start of year 1; out-of-range year and month are clamped,
	// the day field is added as is.
	function automatic int unsigned day_number(input logic [YEAR_W-1:0] y,
			input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
		int unsigned yy;
		int unsigned mm;
		int unsigned p;
		int unsigned s;
		yy = 32'((y < YEAR_MIN) ? YEAR_MIN : (y > YEAR_MAX) ? YEAR_MAX : y);
		mm = 32'((m < MONTH_MIN) ? MONTH_MIN : (m > MONTH_MAX) ? MONTH_MAX : m);
		p = yy - 1;
		s = 365 * p + p / 4 - p / 100 + p / 400;
		case (mm)
			2:       s += 31;
			3:       s += 59;
			4:       s += 90;
			5:       s += 120;
			6:       s += 151;
			7:       s += 181;
			8:       s += 212;
			9:       s += 243;
			10:      s += 273;
			11:      s += 304;
			12:      s += 334;
			default: s += 0;
		endcase
		if (mm > 32'(MONTH_FEB)
				&& (((yy % 4) == 0 && (yy % 100) != 0) || (yy % 400) == 0))
			s += 1;
		return s + 32'(d);
	endfunction

	function automatic date_gap_t predict_gap(
			input logic [YEAR_W-1:0] sy, input logic [MONTH_W-1:0] sm,
			input logic [DAY_W-1:0] sd, input logic [YEAR_W-1:0] ey,
			input logic [MONTH_W-1:0] em, input logic [DAY_W-1:0] ed);
		int unsigned a;
		int unsigned b;
		date_gap_t   g;
		a = day_number(sy, sm, sd);
		b = day_number(ey, em, ed);
		if (b < a) begin
			g.day_count   = '0;
			g.order_error = 1'b1;
		end else begin
			g.day_count   = COUNT_W'(b - a);
			g.order_error = 1'b0;
		end
		return g;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// One request transfer: optional idle gap, then hold the payload until taken.
	task automatic send_dates(input logic [YEAR_W-1:0] sy, input logic [MONTH_W-1:0] sm,
			input logic [DAY_W-1:0] sd, input logic [YEAR_W-1:0] ey,
			input logic [MONTH_W-1:0] em, input logic [DAY_W-1:0] ed);
		int unsigned gap;
		gap = $urandom_range(send_idle_max, 0);
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start_year  = sy;
		start_month = sm;
		start_day   = sd;
		end_year    = ey;
		end_month   = em;
		end_day     = ed;
		in_valid    = 1'b1;
		do @(posedge clk); while (in_stall);
		pending_gaps.push_back(predict_gap(sy, sm, sd, ey, em, ed));
		pairs_sent++;
	endtask

	task automatic release_inputs();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_gaps.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_valid();
		send_dates(YEAR_W'($urandom_range(9999, 1)), MONTH_W'($urandom_range(12, 1)),
			DAY_W'($urandom_range(31, 1)), YEAR_W'($urandom_range(9999, 1)),
			MONTH_W'($urandom_range(12, 1)), DAY_W'($urandom_range(31, 1)));
	endtask

	task automatic test_directed_dates();
		send_dates(14'd2024, 4'd3, 5'd15, 14'd2024, 4'd3, 5'd15);
		send_dates(14'd2024, 4'd3, 5'd15, 14'd2024, 4'd3, 5'd16);
		send_dates(14'd2024, 4'd3, 5'd16, 14'd2024, 4'd3, 5'd15);
		send_dates(14'd1, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31);
		send_dates(14'd9999, 4'd12, 5'd31, 14'd1, 4'd1, 5'd1);
		send_dates(14'd1, 4'd1, 5'd1, 14'd1, 4'd1, 5'd2);
		// century and leap-year rules around the end of February and across year ends
		send_dates(14'd1900, 4'd2, 5'd28, 14'd1900, 4'd3, 5'd1);
		send_dates(14'd2000, 4'd2, 5'd28, 14'd2000, 4'd3, 5'd1);
		send_dates(14'd2100, 4'd2, 5'd28, 14'd2100, 4'd3, 5'd1);
		send_dates(14'd2004, 4'd1, 5'd1, 14'd2005, 4'd1, 5'd1);
		send_dates(14'd1999, 4'd12, 5'd31, 14'd2000, 4'd1, 5'd1);
		send_dates(14'd400, 4'd12, 5'd31, 14'd401, 4'd1, 5'd1);
		// clamped year and month
		send_dates(14'd0, 4'd6, 5'd1, 14'd1, 4'd6, 5'd1);
		send_dates(14'h3FFF, 4'd1, 5'd1, 14'd9999, 4'd1, 5'd1);
		send_dates(14'd9999, 4'd12, 5'd31, 14'h3FFF, 4'd12, 5'd31);
		send_dates(14'd2020, 4'd0, 5'd10, 14'd2020, 4'd1, 5'd10);
		send_dates(14'd2020, 4'd12, 5'd5, 14'd2020, 4'd15, 5'd5);
		// day zero and days past the month end
		send_dates(14'd2020, 4'd3, 5'd0, 14'd2020, 4'd2, 5'd29);
		send_dates(14'd2021, 4'd2, 5'd30, 14'd2021, 4'd3, 5'd2);
		send_dates(14'd2021, 4'd4, 5'd31, 14'd2021, 4'd5, 5'd1);
		send_dates('0, '0, '0, '1, '1, '1);
		send_dates('1, '1, '1, '0, '0, '0);
		release_inputs();
	endtask

	task automatic test_random_dates();
		logic [YEAR_W-1:0]  sy;
		logic [MONTH_W-1:0] sm;
		logic [DAY_W-1:0]   sd;
		logic [YEAR_W-1:0]  ey;
		logic [MONTH_W-1:0] em;
		logic [DAY_W-1:0]   ed;
		int                 yr;
		int unsigned        kind;
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			kind = $urandom_range(9, 0);
			sy = YEAR_W'($urandom_range(9999, 1));
			sm = MONTH_W'($urandom_range(12, 1));
			sd = DAY_W'($urandom_range(31, 1));
			ey = YEAR_W'($urandom_range(9999, 1));
			em = MONTH_W'($urandom_range(12, 1));
			ed = DAY_W'($urandom_range(31, 1));
			if (kind >= 4 && kind <= 6) begin
				// same or neighboring year, either order
				yr = int'(sy) + $urandom_range(2, 0) - 1;
				ey = (yr < 1) ? 14'd1 : (yr > 9999) ? 14'd9999 : YEAR_W'(yr);
			end else if (kind == 7) begin
				ey = sy;
				em = sm;
			end else if (kind >= 8) begin
				{sy, sm, sd} = DATE_W'($urandom);
				{ey, em, ed} = DATE_W'($urandom);
			end
			send_dates(sy, sm, sd, ey, em, ed);
		end
		release_inputs();
	endtask

	task automatic test_back_to_back();
		send_idle_max = 0;
		sink_idle_max = 0;
		repeat (50) send_random_valid();
		release_inputs();
		send_idle_max = 10;
		sink_idle_max = 10;
	endtask

	// Output held off for a long stretch while requests keep coming.
	task automatic test_output_hold();
		wait_idle();
		send_idle_max = 0;
		sink_hold     = 300;
		repeat (25) send_random_valid();
		release_inputs();
		send_idle_max = 10;
	endtask

	initial begin : result_sink
		int unsigned gap;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (sink_hold != 0) begin
				gap       = sink_hold;
				sink_hold = 0;
			end else begin
				gap = $urandom_range(sink_idle_max, 0);
			end
			if (gap != 0) begin
				out_stall = 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (order_error)
				errors_seen++;
			if (pending_gaps.size() == 0) begin
				report_mismatch($sformatf("result with no request pending: count=%0d err=%0b",
					day_count, order_error));
			end else begin
				want = pending_gaps.pop_front();
				if (day_count !== want.day_count)
					report_mismatch($sformatf("day_count %0d, predicted %0d",
						day_count, want.day_count));
				if (order_error !== want.order_error)
					report_mismatch($sformatf("order_error %0b, predicted %0b",
						order_error, want.order_error));
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		start_year  = '0;
		start_month = '0;
		start_day   = '0;
		end_year    = '0;
		end_month   = '0;
		end_day     = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_dates();
		test_random_dates();
		test_back_to_back();
		test_output_hold();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d date pairs sent (edge dates, random and clamped fields, back-to-back,",
			pairs_sent);
		$display("long output hold); %0d results checked, %0d out of order",
			results_seen, errors_seen);
		if (mismatches == 0 && pending_gaps.size() == 0) begin
			$display("gregorian_day_difference_top: match");
		end else begin
			$display("gregorian_day_difference_top: mismatch");
		end
		$finish;
	end

endmodule
